@@ rtl/core/gdfw_pkg.sv @@
package gdfw_pkg;

    localparam int VERT_W  = 4;   // vertex field width
    localparam int KIND_W  = 2;   // item kind width
    localparam int STAT_W  = 2;   // result status width
    localparam int TDATA_W = 8;   // byte-padded tdata width

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_WALK   = 2'd2
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_MISS  = 2'd2,
        ST_VISIT = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load;        // latch input word
        logic own_b;       // list owner is second vertex
        logic sel_top;     // degree lookup on stack top vertex
        logic deg_latch;   // latch owner degree, clear scan index
        logic add_wr;      // append to owner list
        logic rm_rd;       // read owner entry at scan index
        logic rm_next;     // advance scan index
        logic sh_rd;       // read owner entry above scan index
        logic sh_wr;       // move that entry down one place
        logic deg_dec;     // shorten owner list
        logic set_full;
        logic set_miss;
        logic wk_init;     // clear visited, push start vertex
        logic wk_step;     // fetch next neighbor of top, or pop
        logic wk_push;     // mark and push fetched neighbor
        logic emit_edge;
        logic emit_visit;
        logic emit_last;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] in_kind;
        logic in_range;
        logic a_ok;
        logic add_full;
        logic deg_zero;
        logic rm_match;
        logic rm_more;
        logic sh_more;
        logic top_has;
        logic depth_one;
        logic nb_new;
        logic out_free;
    } t_dp_sts;

endpackage

@@ rtl/core/gdfw_ram.sv @@
module gdfw_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/gdfw_ctrl.sv @@
module gdfw_ctrl import gdfw_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [15:0] {
        S_IDLE    = 16'b0000_0000_0000_0001,
        S_ADD_CK0 = 16'b0000_0000_0000_0010,
        S_ADD_CK1 = 16'b0000_0000_0000_0100,
        S_ADD_WA  = 16'b0000_0000_0000_1000,
        S_ADD_WB  = 16'b0000_0000_0001_0000,
        S_RM_CHK  = 16'b0000_0000_0010_0000,
        S_RM_DEG  = 16'b0000_0000_0100_0000,
        S_RM_RD   = 16'b0000_0000_1000_0000,
        S_RM_CMP  = 16'b0000_0001_0000_0000,
        S_RM_SHRD = 16'b0000_0010_0000_0000,
        S_RM_SHWR = 16'b0000_0100_0000_0000,
        S_WK_INIT = 16'b0000_1000_0000_0000,
        S_WK_TOP  = 16'b0001_0000_0000_0000,
        S_WK_NB   = 16'b0010_0000_0000_0000,
        S_WK_END  = 16'b0100_0000_0000_0000,
        S_EMIT    = 16'b1000_0000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_own_b, n_own_b;

    always_comb begin
        n_state     = r_state;
        n_own_b     = r_own_b;
        o_cmd       = '0;
        o_cmd.own_b = r_own_b;
        o_in_ready  = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_own_b    = 1'b0;
                    unique case (i_sts.in_kind)
                        KIND_ADD:    n_state = S_ADD_CK0;
                        KIND_REMOVE: n_state = S_RM_CHK;
                        KIND_WALK:   n_state = S_WK_INIT;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_CK0: begin
                o_cmd.own_b     = 1'b0;
                o_cmd.deg_latch = 1'b1;
                n_state         = S_ADD_CK1;
            end
            S_ADD_CK1: begin
                o_cmd.own_b = 1'b1;
                if (!i_sts.in_range || i_sts.add_full) begin
                    o_cmd.set_full = 1'b1;
                    n_state        = S_EMIT;
                end else begin
                    n_state = S_ADD_WA;
                end
            end
            S_ADD_WA: begin
                o_cmd.own_b  = 1'b0;
                o_cmd.add_wr = 1'b1;
                n_state      = S_ADD_WB;
            end
            S_ADD_WB: begin
                o_cmd.own_b  = 1'b1;
                o_cmd.add_wr = 1'b1;
                n_state      = S_EMIT;
            end
            S_RM_CHK: begin
                if (!i_sts.in_range) begin
                    o_cmd.set_miss = 1'b1;
                    n_state        = S_EMIT;
                end else begin
                    n_state = S_RM_DEG;
                end
            end
            S_RM_DEG: begin
                o_cmd.deg_latch = 1'b1;
                if (i_sts.deg_zero) begin
                    o_cmd.set_miss = 1'b1;
                    n_own_b        = 1'b1;
                    n_state        = r_own_b ? S_EMIT : S_RM_DEG;
                end else begin
                    n_state = S_RM_RD;
                end
            end
            S_RM_RD: begin
                o_cmd.rm_rd = 1'b1;
                n_state     = S_RM_CMP;
            end
            S_RM_CMP: begin
                if (i_sts.rm_match) begin
                    if (i_sts.rm_more) begin
                        n_state = S_RM_SHRD;
                    end else begin
                        o_cmd.deg_dec = 1'b1;
                        n_own_b       = 1'b1;
                        n_state       = r_own_b ? S_EMIT : S_RM_DEG;
                    end
                end else if (i_sts.rm_more) begin
                    o_cmd.rm_next = 1'b1;
                    n_state       = S_RM_RD;
                end else begin
                    o_cmd.set_miss = 1'b1;
                    n_own_b        = 1'b1;
                    n_state        = r_own_b ? S_EMIT : S_RM_DEG;
                end
            end
            S_RM_SHRD: begin
                o_cmd.sh_rd = 1'b1;
                n_state     = S_RM_SHWR;
            end
            S_RM_SHWR: begin
                o_cmd.sh_wr = 1'b1;
                if (i_sts.sh_more) begin
                    n_state = S_RM_SHRD;
                end else begin
                    o_cmd.deg_dec = 1'b1;
                    n_own_b       = 1'b1;
                    n_state       = r_own_b ? S_EMIT : S_RM_DEG;
                end
            end
            S_WK_INIT: begin
                if (!i_sts.a_ok) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.wk_init = 1'b1;
                    n_state       = S_WK_TOP;
                end
            end
            S_WK_TOP: begin
                o_cmd.sel_top = 1'b1;
                o_cmd.wk_step = 1'b1;
                if (i_sts.top_has) begin
                    n_state = S_WK_NB;
                end else if (i_sts.depth_one) begin
                    n_state = S_WK_END;
                end
            end
            S_WK_NB: begin
                if (!i_sts.nb_new) begin
                    n_state = S_WK_TOP;
                end else if (i_sts.out_free) begin
                    o_cmd.emit_visit = 1'b1;
                    o_cmd.wk_push    = 1'b1;
                    n_state          = S_WK_TOP;
                end
            end
            S_WK_END: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_edge = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_own_b <= 1'b0;
        end else begin
            r_state <= n_state;
            r_own_b <= n_own_b;
        end
    end

endmodule

@@ rtl/core/gdfw_dp.sv @@
module gdfw_dp import gdfw_pkg::*; #(
    parameter int VERTEX_COUNT = 16,
    parameter int MAX_DEGREE   = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic [KIND_W-1:0] i_in_kind,
    input  logic [VERT_W-1:0] i_in_first,
    input  logic [VERT_W-1:0] i_in_second,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [VERT_W-1:0] o_out_vertex,
    output logic              o_out_last,
    output t_status           o_out_status
);

    localparam int VW    = $clog2(VERTEX_COUNT);
    localparam int DW    = $clog2(MAX_DEGREE + 1);
    localparam int PW    = $clog2(VERTEX_COUNT + 1);
    localparam int DEPTH = VERTEX_COUNT * MAX_DEGREE;
    localparam int AW    = $clog2(DEPTH);

    function automatic logic [AW-1:0] addr_of(input logic [VERT_W-1:0] v,
                                              input logic [DW-1:0] i);
        return AW'(32'(v) * 32'(MAX_DEGREE) + 32'(i));
    endfunction

    logic [VERT_W-1:0] r_a, r_b;
    logic [DW-1:0]     r_deg [VERTEX_COUNT];
    logic [DW-1:0]     r_n, r_idx;
    t_status           r_st;
    logic [VERTEX_COUNT-1:0] r_visited;
    logic [VERT_W-1:0] r_stk_vert [VERTEX_COUNT];
    logic [DW-1:0]     r_stk_next [VERTEX_COUNT];
    logic [PW-1:0]     r_depth;
    logic [VERT_W-1:0] r_pend;
    logic              r_out_valid;
    logic [VERT_W-1:0] r_out_vertex;
    logic              r_out_last;
    t_status           r_out_status;

    logic [VERT_W-1:0] own_vert, val_vert, top_vert;
    logic [VW-1:0]     own_ix, top_ix, deg_ix;
    logic [DW-1:0]     deg_rd, top_next, idx_p1;
    logic              top_has, out_free;
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [VERT_W-1:0] ram_wdata, ram_rdata;

    assign own_vert = i_cmd.own_b ? r_b : r_a;
    assign val_vert = i_cmd.own_b ? r_a : r_b;
    assign own_ix   = VW'(own_vert);
    assign top_ix   = VW'(r_depth - PW'(1));
    assign top_vert = r_stk_vert[top_ix];
    assign top_next = r_stk_next[top_ix];
    assign deg_ix   = i_cmd.sel_top ? VW'(top_vert) : own_ix;
    assign deg_rd   = r_deg[deg_ix];
    assign idx_p1   = r_idx + DW'(1);
    assign top_has  = top_next < deg_rd;
    assign out_free = !r_out_valid || i_out_ready;

    // adjacency rows: one row of MAX_DEGREE entries per vertex
    assign ram_we    = i_cmd.add_wr || i_cmd.sh_wr;
    assign ram_waddr = i_cmd.add_wr ? addr_of(own_vert, deg_rd) : addr_of(own_vert, r_idx);
    assign ram_wdata = i_cmd.add_wr ? val_vert : ram_rdata;
    assign ram_re    = i_cmd.rm_rd || i_cmd.sh_rd || (i_cmd.wk_step && top_has);
    assign ram_raddr = i_cmd.wk_step ? addr_of(top_vert, top_next) :
                       i_cmd.sh_rd   ? addr_of(own_vert, idx_p1) :
                                       addr_of(own_vert, r_idx);

    gdfw_ram #(
        .WIDTH (VERT_W),
        .DEPTH (DEPTH)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_sts           = '0;
        o_sts.in_kind   = i_in_kind;
        o_sts.a_ok      = 32'(r_a) < VERTEX_COUNT;
        o_sts.in_range  = (32'(r_a) < VERTEX_COUNT) && (32'(r_b) < VERTEX_COUNT);
        if (r_a == r_b) begin
            o_sts.add_full = (32'(r_n) + 32'd2) > MAX_DEGREE;
        end else begin
            o_sts.add_full = (32'(r_n) >= MAX_DEGREE) || (32'(deg_rd) >= MAX_DEGREE);
        end
        o_sts.deg_zero  = (deg_rd == '0);
        o_sts.rm_match  = (ram_rdata == val_vert);
        o_sts.rm_more   = ((DW+1)'(r_idx) + (DW+1)'(1)) < (DW+1)'(r_n);
        o_sts.sh_more   = ((DW+1)'(r_idx) + (DW+1)'(2)) < (DW+1)'(r_n);
        o_sts.top_has   = top_has;
        o_sts.depth_one = (r_depth == PW'(1));
        o_sts.nb_new    = !r_visited[VW'(ram_rdata)];
        o_sts.out_free  = out_free;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg       <= '{default: '0};
            r_visited   <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.add_wr) begin
                r_deg[own_ix] <= deg_rd + DW'(1);
            end else if (i_cmd.deg_dec) begin
                r_deg[own_ix] <= deg_rd - DW'(1);
            end
            if (i_cmd.wk_init) begin
                // only the start vertex is marked
                r_visited <= VERTEX_COUNT'(1) << r_a;
                r_depth   <= PW'(1);
            end else if (i_cmd.wk_push) begin
                r_visited[VW'(ram_rdata)] <= 1'b1;
                r_depth                   <= r_depth + PW'(1);
            end else if (i_cmd.wk_step && !top_has) begin
                r_depth <= r_depth - PW'(1);
            end
            if (i_cmd.emit_edge || i_cmd.emit_visit || i_cmd.emit_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a  <= i_in_first;
            r_b  <= i_in_second;
            r_st <= ST_DONE;
        end else if (i_cmd.set_full) begin
            r_st <= ST_FULL;
        end else if (i_cmd.set_miss) begin
            r_st <= ST_MISS;
        end
        if (i_cmd.deg_latch) begin
            r_n   <= deg_rd;
            r_idx <= '0;
        end else if (i_cmd.rm_next || i_cmd.sh_wr) begin
            r_idx <= idx_p1;
        end
        if (i_cmd.wk_init) begin
            r_stk_vert[0] <= r_a;
            r_stk_next[0] <= '0;
            r_pend        <= r_a;
        end else if (i_cmd.wk_push) begin
            r_stk_vert[VW'(r_depth)] <= ram_rdata;
            r_stk_next[VW'(r_depth)] <= '0;
            r_pend                   <= ram_rdata;
        end else if (i_cmd.wk_step && top_has) begin
            r_stk_next[top_ix] <= top_next + DW'(1);
        end
        if (i_cmd.emit_edge) begin
            r_out_vertex <= '0;
            r_out_last   <= 1'b1;
            r_out_status <= r_st;
        end else if (i_cmd.emit_visit || i_cmd.emit_last) begin
            // a visit goes out only once the next one is known, so the final one carries last
            r_out_vertex <= r_pend;
            r_out_last   <= i_cmd.emit_last;
            r_out_status <= ST_VISIT;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_vertex = r_out_vertex;
    assign o_out_last   = r_out_last;
    assign o_out_status = r_out_status;

endmodule

@@ rtl/core/graph_depth_first_walk.sv @@
// Undirected multigraph kept as ordered adjacency lists, one row of MAX_DEGREE
// entries per vertex in a single-port-write, registered-read RAM, with the list
// lengths in flops. An add item (tuser 0) appends each end to the other's list
// and answers one word with status 0, or status 1 if a list is full or a vertex
// is out of range. A remove item (tuser 1) searches each list for the first
// match and closes the gap by moving the tail down, answering status 0, or 2
// when either search misses. A walk item (tuser 2) clears the visited map and
// sends the reachable vertices in depth-first preorder, neighbors in list
// order, tlast on the final one; a start vertex out of range gives no word, as
// does tuser 3. The walk runs on an explicit stack and is bound by the RAM
// read port. Items are taken one at a time; a new item is taken while the last
// result still waits in the output register.
module graph_depth_first_walk import gdfw_pkg::*; #(
    parameter int VERTEX_COUNT = 16,
    parameter int MAX_DEGREE   = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input words
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // [3:0] first_vertex, [7:4] second_vertex
    input  logic [KIND_W-1:0]  s_axis_tuser,   // [1:0] kind
    // result words
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [3:0] vertex, [7:4] zero
    output logic [STAT_W-1:0]  m_axis_tuser,   // [1:0] status
    output logic               m_axis_tlast    // last word of the item
);

    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic [VERT_W-1:0] out_vertex;
    t_status           out_status;

    // sequencer: one state per step of add, remove scan/shift and walk
    gdfw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // lists, degrees, visited map, stack and output register
    gdfw_dp #(
        .VERTEX_COUNT (VERTEX_COUNT),
        .MAX_DEGREE   (MAX_DEGREE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_in_kind    (s_axis_tuser),
        .i_in_first   (s_axis_tdata[VERT_W-1:0]),
        .i_in_second  (s_axis_tdata[2*VERT_W-1:VERT_W]),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_vertex (out_vertex),
        .o_out_last   (m_axis_tlast),
        .o_out_status (out_status)
    );

    assign m_axis_tdata = {{(TDATA_W-VERT_W){1'b0}}, out_vertex};
    assign m_axis_tuser = out_status;

endmodule

@@ bench/tb_graph_depth_first_walk.sv @@
`timescale 1ns / 1ps

module tb_graph_depth_first_walk import gdfw_pkg::*; ();

    localparam int VERTEX_COUNT = 16;
    localparam int MAX_DEGREE   = 8;
    localparam int RANDOM_ITEMS = 355;
    // drain time after the last expected word, to catch stray words
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 800000;

    // kind code the block has no use for, it must stay silent
    localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [VERT_W-1:0] first_vertex;
        logic [VERT_W-1:0] second_vertex;
    } t_item;

    typedef struct packed {
        logic [VERT_W-1:0] vertex;
        logic              last;
        t_status           status;
    } t_result;

    // receiver stall styles
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_STINGY,
        RX_PERIODIC
    } t_rx_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata = '0;   // [3:0] first_vertex, [7:4] second_vertex
    logic [KIND_W-1:0]  s_axis_tuser = '0;   // [1:0] kind
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;        // [3:0] vertex, [7:4] zero
    logic [STAT_W-1:0]  m_axis_tuser;        // [1:0] status
    logic               m_axis_tlast;

    graph_depth_first_walk #(
        .VERTEX_COUNT (VERTEX_COUNT),
        .MAX_DEGREE   (MAX_DEGREE)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // shadow graph: ordered adjacency lists, same as the block keeps them
    // ------------------------------------------------------------------
    logic [VERT_W-1:0] adj_list [VERTEX_COUNT][MAX_DEGREE];
    int                adj_len  [VERTEX_COUNT] = '{default: 0};
    bit                visited  [VERTEX_COUNT];

    t_item   queued_items [$];   // words waiting for the driver
    t_result awaited_words [$];  // results still owed by the block
    bit      fail_seen = 1'b0;
    bit      word_taken = 1'b0;  // input handshake seen at the last rising edge
    int      cycle_count = 0;

    // one more result word owed by the block
    function automatic void owe_word(input logic [VERT_W-1:0] vertex, input logic last,
                                     input t_status status);
        t_result w;
        w.vertex = vertex;
        w.last   = last;
        w.status = status;
        awaited_words.insert(awaited_words.size(), w);
    endfunction

    function automatic void append_neighbor(input int owner, input logic [VERT_W-1:0] value);
        adj_list[owner][adj_len[owner]] = value;
        adj_len[owner]++;
    endfunction

    // first matching entry goes, the tail moves down one place
    function automatic bit drop_neighbor(input int owner, input logic [VERT_W-1:0] value);
        for (int i = 0; i < adj_len[owner]; i++) begin
            if (adj_list[owner][i] == value) begin
                for (int j = i; j < adj_len[owner] - 1; j++)
                    adj_list[owner][j] = adj_list[owner][j + 1];
                adj_len[owner]--;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void add_edge(input logic [VERT_W-1:0] a, input logic [VERT_W-1:0] b);
        t_status st;
        st = ST_DONE;
        if (a == b) begin
            // a self-loop takes two entries of the one list
            if (adj_len[a] + 2 > MAX_DEGREE) st = ST_FULL;
        end else if (adj_len[a] >= MAX_DEGREE || adj_len[b] >= MAX_DEGREE) begin
            st = ST_FULL;
        end
        if (st == ST_DONE) begin
            append_neighbor(a, b);
            append_neighbor(b, a);
        end
        owe_word('0, 1'b1, st);
    endfunction

    function automatic void remove_edge(input logic [VERT_W-1:0] a, input logic [VERT_W-1:0] b);
        bit hit_a;
        bit hit_b;
        // both searches run even if the first one misses
        hit_a = drop_neighbor(a, b);
        hit_b = drop_neighbor(b, a);
        owe_word('0, 1'b1, (hit_a && hit_b) ? ST_DONE : ST_MISS);
    endfunction

    // depth-first preorder from start, neighbors in list order
    function automatic void walk_preorder(input logic [VERT_W-1:0] start);
        logic [VERT_W-1:0] order    [VERTEX_COUNT];
        logic [VERT_W-1:0] stk_vert [VERTEX_COUNT];
        int                stk_next [VERTEX_COUNT];
        int                depth;
        int                n;
        int                top;
        logic [VERT_W-1:0] nb;
        for (int v = 0; v < VERTEX_COUNT; v++) visited[v] = 1'b0;
        visited[start] = 1'b1;
        order[0] = start;
        n = 1;
        stk_vert[0] = start;
        stk_next[0] = 0;
        depth = 1;
        while (depth > 0) begin
            top = depth - 1;
            if (stk_next[top] < adj_len[stk_vert[top]]) begin
                nb = adj_list[stk_vert[top]][stk_next[top]];
                stk_next[top]++;
                if (!visited[nb] && depth < VERTEX_COUNT) begin
                    visited[nb] = 1'b1;
                    order[n] = nb;
                    n++;
                    stk_vert[depth] = nb;
                    stk_next[depth] = 0;
                    depth++;
                end
            end else begin
                depth--;
            end
        end
        for (int i = 0; i < n; i++)
            owe_word(order[i], (i == n - 1), ST_VISIT);
    endfunction

    task automatic queue_item(input logic [KIND_W-1:0] kind, input int a, input int b);
        t_item it;
        it.kind          = kind;
        it.first_vertex  = VERT_W'(a);
        it.second_vertex = VERT_W'(b);
        queued_items.insert(queued_items.size(), it);
    endtask

    // ------------------------------------------------------------------
    // driver: bursts of words with random gaps, changes on the falling edge
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge i_clk) begin : drive_words
        t_item nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || word_taken) begin
            if (gap_left > 0 || queued_items.size() == 0) begin
                if (gap_left > 0) gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
                // junk on the bus while idle
                s_axis_tdata  <= TDATA_W'($urandom);
                s_axis_tuser  <= KIND_W'($urandom);
            end else begin
                nxt = queued_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {nxt.second_vertex, nxt.first_vertex};
                s_axis_tuser  <= nxt.kind;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: stall style is redrawn at random after a random countdown in cycles
    // ------------------------------------------------------------------
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_mode_left = 0;
    int       rx_phase = 0;

    always @(negedge i_clk) begin
        rx_phase <= rx_phase + 1;
        if (rx_mode_left == 0) begin
            rx_mode      <= t_rx_mode'($urandom_range(0, 3));
            rx_mode_left <= $urandom_range(20, 200);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            RX_OPEN:     m_axis_tready <= 1'b1;
            RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
            RX_STINGY:   m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:     m_axis_tready <= (rx_phase % 5) != 0;
        endcase
    end

    // ------------------------------------------------------------------
    // monitor: check result words, then feed accepted input words to the shadow graph
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_ports
        t_result want;
        if (!i_rst_n) begin
            word_taken <= 1'b0;
        end else begin
            word_taken <= s_axis_tvalid && s_axis_tready;

            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_words.size() == 0) begin
                    $error("unexpected result word: vertex %0d status %0d last %0b",
                           m_axis_tdata[VERT_W-1:0], m_axis_tuser, m_axis_tlast);
                    fail_seen = 1'b1;
                end else begin
                    want = awaited_words.pop_front();
                    if (m_axis_tdata[VERT_W-1:0] !== want.vertex) begin
                        $error("vertex: expected %0d, got %0d",
                               want.vertex, m_axis_tdata[VERT_W-1:0]);
                        fail_seen = 1'b1;
                    end
                    if (m_axis_tdata[TDATA_W-1:VERT_W] !== '0) begin
                        $error("tdata pad: expected 0, got %0h",
                               m_axis_tdata[TDATA_W-1:VERT_W]);
                        fail_seen = 1'b1;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
                        fail_seen = 1'b1;
                    end
                    if (m_axis_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                        fail_seen = 1'b1;
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                case (s_axis_tuser)
                    KIND_ADD:    add_edge(s_axis_tdata[3:0], s_axis_tdata[7:4]);
                    KIND_REMOVE: remove_edge(s_axis_tdata[3:0], s_axis_tdata[7:4]);
                    KIND_WALK:   walk_preorder(s_axis_tdata[3:0]);
                    default:     ;  // unused kind, no word comes back
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** graph_depth_first_walk: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin : run_test
        logic [7:0] live_edges [$];  // edges believed present, for removes that hit
        logic [7:0] pick;
        int         counted;
        int         r;
        int         a;
        int         b;
        int         idx;

        // directed part
        queue_item(KIND_WALK, 0, 0);          // walk on an empty graph, start only
        queue_item(KIND_ADD, 0, 15);          // extreme vertices
        queue_item(KIND_ADD, 15, 15);         // self-loop, two entries in one list
        queue_item(KIND_ADD, 0, 15);          // duplicate edge
        queue_item(KIND_WALK, 15, 0);
        queue_item(KIND_REMOVE, 0, 15);       // first match only
        queue_item(KIND_REMOVE, 3, 9);        // nothing to remove
        for (int v = 2; v <= 9; v++)
            queue_item(KIND_ADD, 1, v);       // fill the list of vertex 1
        queue_item(KIND_ADD, 1, 10);          // list full
        queue_item(KIND_ADD, 2, 2);           // self-loop with room
        queue_item(KIND_REMOVE, 1, 9);        // one free entry left
        queue_item(KIND_ADD, 1, 1);           // self-loop needs two, rejected
        queue_item(KIND_ADD, 1, 11);          // last free entry taken
        queue_item(KIND_WALK, 1, 15);
        queue_item(KIND_IGNORED, 15, 15);
        queue_item(KIND_REMOVE, 15, 15);      // self-loop removal
        queue_item(KIND_REMOVE, 15, 15);      // gone now
        queue_item(KIND_WALK, 12, 15);        // isolated vertex

        // random part, mostly adds and removes of known edges plus walks
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            r = int'($urandom_range(0, 99));
            a = int'($urandom_range(0, VERTEX_COUNT - 1));
            b = int'($urandom_range(0, VERTEX_COUNT - 1));
            if (r < 40) begin
                if ($urandom_range(0, 3) == 0) a = int'($urandom_range(0, 2));  // crowd a few lists
                if ($urandom_range(0, 19) == 0) b = a;
                queue_item(KIND_ADD, a, b);
                live_edges.insert(live_edges.size(), {VERT_W'(a), VERT_W'(b)});
            end else if (r < 70) begin
                if (live_edges.size() != 0 && $urandom_range(0, 4) != 0) begin
                    idx  = int'($urandom_range(0, live_edges.size() - 1));
                    pick = live_edges[idx];
                    live_edges.delete(idx);
                    if ($urandom_range(0, 1) == 1) begin
                        a = int'(pick[3:0]);
                        b = int'(pick[7:4]);
                    end else begin
                        a = int'(pick[7:4]);
                        b = int'(pick[3:0]);
                    end
                end
                queue_item(KIND_REMOVE, a, b);
            end else if (r < 92) begin
                queue_item(KIND_WALK, a, b);
            end else begin
                queue_item(KIND_IGNORED, a, b);
            end
            counted++;
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (queued_items.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (awaited_words.size() != 0) @(posedge i_clk);
        // catch stray words after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (!fail_seen && awaited_words.size() == 0) begin
            $display("** graph_depth_first_walk: PASSED **");
        end else begin
            $display("** graph_depth_first_walk: FAILED **");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/gdfw_pkg.sv
rtl/core/gdfw_ram.sv
rtl/core/gdfw_ctrl.sv
rtl/core/gdfw_dp.sv
rtl/core/graph_depth_first_walk.sv
bench/tb_graph_depth_first_walk.sv
